// ===== rtl/lbis_pkg.sv =====
// ---------------------------------------------------------------------------
// lbis_pkg: shared types and constants of the LED indicator sequencer
// Field widths, ramp table constants, derived reciprocal multipliers and
// the job descriptor passed from the front end to the command engine.
// ---------------------------------------------------------------------------
package lbis_pkg;

    // Field widths of the input item and the command item.
    localparam int COLOR_W = 24;
    localparam int TIME_W  = 16;
    localparam int LEVEL_W = 8;
    localparam int VALUE_W = 12;
    localparam int INDEX_W = 6;
    localparam int PCT_W   = 7;

    // Ramp table shape.
    localparam int DUTY_STEPS = 50;
    localparam int RAMP_MS    = 500;

    // Duty percent constants. The dimmed table is scaled by 400/5 = 80.
    localparam int FULL_PCT  = 100;
    localparam int DIM_BASE  = 20;
    localparam int DIM_CAP   = 80;
    localparam int DIM_SCALE = 80;

    // Light selector codes.
    localparam logic LIGHT_NOTIFY  = 1'b0;
    localparam logic LIGHT_BATTERY = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // Sum of the two raised blink times and the resulting step.
    localparam longint unsigned TIME_MAX = 65535;
    localparam longint unsigned SUM_MAX  = 2 * TIME_MAX;
    localparam int              SUM_W    = $clog2(SUM_MAX + 1);
    localparam longint unsigned STEP_MAX = SUM_MAX / DUTY_STEPS;
    localparam int              STEP_W   = $clog2(STEP_MAX + 1);

    // Reciprocal for sum / DUTY_STEPS. The shift is chosen so that
    // x * DUTY_STEPS stays below 2^shift for every x, which makes the
    // rounded-up reciprocal exact after flooring.
    localparam int              STEP_SH    = $clog2(SUM_MAX * DUTY_STEPS + 1);
    localparam longint unsigned STEP_MUL   =
        ((64'd1 << STEP_SH) + DUTY_STEPS - 1) / DUTY_STEPS;
    localparam int              STEP_MUL_W = $clog2(STEP_MUL + 1);

    // Per-entry increment c = scale * step, split as c / RAMP_MS and c % RAMP_MS.
    localparam longint unsigned C_MAX   = STEP_MAX * FULL_PCT;
    localparam int              C_W     = $clog2(C_MAX + 1);
    localparam int              C_SH    = $clog2(C_MAX * RAMP_MS + 1);
    localparam longint unsigned C_MUL   = ((64'd1 << C_SH) + RAMP_MS - 1) / RAMP_MS;
    localparam int              C_MUL_W = $clog2(C_MUL + 1);
    localparam longint unsigned INC_MAX = C_MAX / RAMP_MS;
    localparam int              INC_W   = $clog2(INC_MAX + 1);
    localparam int              REM_W   = $clog2(RAMP_MS + 1);
    localparam int              TQ_W    = ((INC_W > PCT_W) ? INC_W : PCT_W) + 2;

    localparam int IDX_W      = $clog2(DUTY_STEPS);
    localparam int DIV_CNT_W  = $clog2(TIME_W + 1);

    typedef enum logic [1:0] {
        KIND_STEADY = 2'd0,
        KIND_BLINK  = 2'd1,
        KIND_STEP   = 2'd2,
        KIND_DUTY   = 2'd3
    } t_kind;

    typedef struct packed {
        logic               to_red;
        logic               to_green;
        logic [LEVEL_W-1:0] level;
    } t_steady;

    // One job: optional ramp, optional blink enable, then up to two
    // steady level commands.
    typedef struct packed {
        logic              ramp;
        logic              blink;
        logic              dim;
        logic              to_red;
        logic              to_green;
        logic [TIME_W-1:0] on_ms;
        logic [TIME_W-1:0] off_ms;
        logic [1:0]        n_steady;
        t_steady           s0;
        t_steady           s1;
    } t_job;

endpackage

// ===== rtl/lbis_ifs.sv =====
// ---------------------------------------------------------------------------
// lbis channel interfaces
// Valid/ready channels for light updates, the ramp enable register and
// the LED commands.
// ---------------------------------------------------------------------------
interface lbis_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [lbis_pkg::COLOR_W-1:0] color;
    logic                         flash_timed;
    logic [lbis_pkg::TIME_W-1:0]  on_time_ms;
    logic [lbis_pkg::TIME_W-1:0]  off_time_ms;

    modport source(output valid, op, color, flash_timed, on_time_ms, off_time_ms,
                   input ready);
    modport sink(input valid, op, color, flash_timed, on_time_ms, off_time_ms,
                 output ready);
endinterface

interface lbis_cfg_if;
    logic valid;
    logic ready;
    logic ramp_enabled;

    modport source(output valid, ramp_enabled, input ready);
    modport sink(input valid, ramp_enabled, output ready);
endinterface

interface lbis_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic                         to_red;
    logic                         to_green;
    logic [lbis_pkg::VALUE_W-1:0] value;
    logic [lbis_pkg::INDEX_W-1:0] entry_index;
    logic                         last;

    modport source(output valid, kind, to_red, to_green, value, entry_index, last,
                   input ready);
    modport sink(input valid, kind, to_red, to_green, value, entry_index, last,
                 output ready);
endinterface

// ===== rtl/lbis_div.sv =====
// ---------------------------------------------------------------------------
// lbis_div: restoring divider
// Computes the on time divided by the ramp step, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module lbis_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lbis_pkg::TIME_W-1:0]  i_dividend,
    input  logic [lbis_pkg::STEP_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic [lbis_pkg::TIME_W-1:0]  o_quotient
);

    logic                           r_busy;
    logic [lbis_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [lbis_pkg::TIME_W-1:0]    r_quo;
    logic [lbis_pkg::STEP_W-1:0]    r_rem;
    logic [lbis_pkg::STEP_W-1:0]    r_dvs;

    logic [lbis_pkg::STEP_W:0]      trial;
    logic                           fits;

    assign trial = {r_rem, r_quo[lbis_pkg::TIME_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= lbis_pkg::DIV_CNT_W'(lbis_pkg::TIME_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - lbis_pkg::DIV_CNT_W'(1);
            if (r_cnt == lbis_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Dividend bits shift out at the top while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[lbis_pkg::TIME_W-2:0], fits};
            if (fits) begin
                r_rem <= lbis_pkg::STEP_W'(trial - {1'b0, r_dvs});
            end else begin
                r_rem <= lbis_pkg::STEP_W'(trial);
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/lbis_front.sv =====
// ---------------------------------------------------------------------------
// lbis_front: light update front end
// Stores the settings of both lights, picks single, dual or steady
// indication and hands a job descriptor to the queue.
// ---------------------------------------------------------------------------
module lbis_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lbis_in_if.sink          i_in,
    lbis_cfg_if.sink         i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output lbis_pkg::t_job   o_job
);

    logic [lbis_pkg::COLOR_W-1:0] r_color [2];
    logic                         r_flash [2];
    logic [lbis_pkg::TIME_W-1:0]  r_on    [2];
    logic [lbis_pkg::TIME_W-1:0]  r_off   [2];
    logic                         r_ramp_en;

    logic                         accept;
    logic [lbis_pkg::COLOR_W-1:0] e_color [2];
    logic                         e_flash [2];
    logic [lbis_pkg::TIME_W-1:0]  e_on    [2];
    logic [lbis_pkg::TIME_W-1:0]  e_off   [2];
    logic                         e_lit   [2];
    logic                         e_blink [2];
    logic                         job_empty;

    assign i_in.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && !i_full;

    // The light being updated is seen with its new settings.
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            if (i_in.op == 1'(s)) begin
                e_color[s] = i_in.color;
                e_flash[s] = i_in.flash_timed;
                e_on[s]    = i_in.on_time_ms;
                e_off[s]   = i_in.off_time_ms;
            end else begin
                e_color[s] = r_color[s];
                e_flash[s] = r_flash[s];
                e_on[s]    = r_on[s];
                e_off[s]   = r_off[s];
            end
            e_lit[s]   = |e_color[s];
            e_blink[s] = e_flash[s] && (|e_on[s]) && (|e_off[s]);
        end
    end

    always_comb begin
        logic                         sel;
        logic [lbis_pkg::LEVEL_W-1:0] red;
        logic [lbis_pkg::LEVEL_W-1:0] green;
        logic                         notify_blinks;
        sel           = (e_lit[lbis_pkg::LIGHT_BATTERY]) ? lbis_pkg::LIGHT_BATTERY
                                                         : lbis_pkg::LIGHT_NOTIFY;
        red           = e_color[sel][23:16];
        green         = e_color[sel][15:8];
        notify_blinks = e_blink[lbis_pkg::LIGHT_NOTIFY] && !e_blink[lbis_pkg::LIGHT_BATTERY];
        job_empty     = 1'b0;
        o_job         = '0;
        if (e_lit[lbis_pkg::LIGHT_BATTERY] && e_lit[lbis_pkg::LIGHT_NOTIFY]) begin
            // Dual indication: battery colour on red, notification on green.
            if (notify_blinks) begin
                o_job.ramp     = r_ramp_en;
                o_job.blink    = 1'b1;
                o_job.dim      = !((|red) && !(|green));
                o_job.to_green = 1'b1;
                o_job.on_ms    = e_on[lbis_pkg::LIGHT_NOTIFY];
                o_job.off_ms   = e_off[lbis_pkg::LIGHT_NOTIFY];
                o_job.n_steady = 2'd1;
                o_job.s0       = '{to_red: 1'b1, to_green: 1'b0, level: red};
            end else if (e_blink[lbis_pkg::LIGHT_BATTERY]) begin
                o_job.ramp     = r_ramp_en;
                o_job.blink    = 1'b1;
                o_job.to_red   = 1'b1;
                o_job.on_ms    = e_on[lbis_pkg::LIGHT_BATTERY];
                o_job.off_ms   = e_off[lbis_pkg::LIGHT_BATTERY];
                o_job.n_steady = 2'd1;
                o_job.s0       = '{to_red: 1'b0, to_green: 1'b1, level: '0};
            end else begin
                o_job.n_steady = 2'd2;
                o_job.s0       = '{to_red: 1'b1, to_green: 1'b0, level: red};
                o_job.s1       = '{to_red: 1'b0, to_green: 1'b1,
                                   level: lbis_pkg::LEVEL_W'(1)};
            end
        end else if (e_blink[sel]) begin
            // A blink with neither red nor green produces no command.
            job_empty      = !(|red) && !(|green);
            o_job.ramp     = r_ramp_en;
            o_job.blink    = 1'b1;
            o_job.to_red   = |red;
            o_job.to_green = |green;
            o_job.on_ms    = e_on[sel];
            o_job.off_ms   = e_off[sel];
        end else begin
            o_job.n_steady = 2'd2;
            o_job.s0       = '{to_red: 1'b1, to_green: 1'b0, level: red};
            o_job.s1       = '{to_red: 1'b0, to_green: 1'b1, level: green};
        end
    end

    assign o_push = accept && !job_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                r_color[s] <= '0;
                r_flash[s] <= 1'b0;
                r_on[s]    <= '0;
                r_off[s]   <= '0;
            end
            r_ramp_en <= 1'b0;
        end else begin
            if (accept) begin
                r_color[i_in.op] <= i_in.color;
                r_flash[i_in.op] <= i_in.flash_timed;
                r_on[i_in.op]    <= i_in.on_time_ms;
                r_off[i_in.op]   <= i_in.off_time_ms;
            end
            if (i_cfg.valid) begin
                r_ramp_en <= i_cfg.ramp_enabled;
            end
        end
    end

endmodule

// ===== rtl/lbis_queue.sv =====
// ---------------------------------------------------------------------------
// lbis_queue: job queue
// Short FIFO between the front end and the command engine.
// ---------------------------------------------------------------------------
module lbis_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lbis_pkg::t_job   i_job,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output lbis_pkg::t_job   o_job
);

    lbis_pkg::t_job              r_mem [lbis_pkg::QUEUE_DEPTH];
    logic [lbis_pkg::QA_W-1:0]   r_wr;
    logic [lbis_pkg::QA_W-1:0]   r_rd;
    logic [lbis_pkg::QC_W-1:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == lbis_pkg::QC_W'(lbis_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == lbis_pkg::QA_W'(lbis_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wr + lbis_pkg::QA_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == lbis_pkg::QA_W'(lbis_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rd + lbis_pkg::QA_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + lbis_pkg::QC_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - lbis_pkg::QC_W'(1);
            end
        end
    end

endmodule

// ===== rtl/lbis_back.sv =====
// ---------------------------------------------------------------------------
// lbis_back: LED command engine
// Works out the ramp step and table split, then emits ramp, blink and steady
// commands through an output register, one per cycle unless the output stalls.
// ---------------------------------------------------------------------------
module lbis_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_qvalid,
    input  lbis_pkg::t_job   i_job,
    output logic             o_pop,
    lbis_out_if.source       o_out
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'h0001,
        ST_MUL_S = 13'h0002,
        ST_FIX_S = 13'h0004,
        ST_MUL_C = 13'h0008,
        ST_REC_C = 13'h0010,
        ST_QUO_C = 13'h0020,
        ST_REM_C = 13'h0040,
        ST_WAIT  = 13'h0080,
        ST_RSTEP = 13'h0100,
        ST_TABLE = 13'h0200,
        ST_BLINK = 13'h0400,
        ST_STDY0 = 13'h0800,
        ST_STDY1 = 13'h1000
    } t_state;

    t_state r_state;
    t_state n_state;

    lbis_pkg::t_job                                       r_job;
    logic [lbis_pkg::TIME_W-1:0]                          r_on_c;
    logic [lbis_pkg::SUM_W-1:0]                           r_sum;
    logic [lbis_pkg::SUM_W+lbis_pkg::STEP_MUL_W-1:0]      r_prod_s;
    logic [lbis_pkg::STEP_W-1:0]                          r_step;
    logic [lbis_pkg::C_W-1:0]                             r_c;
    logic [lbis_pkg::C_W+lbis_pkg::C_MUL_W-1:0]           r_prod_c;
    logic [lbis_pkg::INC_W-1:0]                           r_inc;
    logic [lbis_pkg::REM_W-1:0]                           r_rem;
    logic [lbis_pkg::TIME_W-1:0]                          r_qp;
    logic [lbis_pkg::IDX_W-1:0]                           r_idx;
    logic                                                 r_fall;
    logic [lbis_pkg::PCT_W-1:0]                           r_tq;
    logic [lbis_pkg::REM_W-1:0]                           r_tr;

    logic                          r_ov;
    logic                          n_ov;
    lbis_pkg::t_kind               r_okind;
    logic                          r_ored;
    logic                          r_ogreen;
    logic [lbis_pkg::VALUE_W-1:0]  r_ovalue;
    logic [lbis_pkg::INDEX_W-1:0]  r_oidx;
    logic                          r_olast;

    logic                          div_busy;
    logic [lbis_pkg::TIME_W-1:0]   div_q;

    logic [lbis_pkg::TIME_W-1:0]   on_clamp;
    logic [lbis_pkg::TIME_W-1:0]   off_clamp;
    logic [lbis_pkg::STEP_W-1:0]   step_raw;

    logic                          can_load;
    logic                          e_emit;
    logic                          fire;
    lbis_pkg::t_kind               e_kind;
    logic                          e_red;
    logic                          e_green;
    logic [lbis_pkg::VALUE_W-1:0]  e_value;
    logic [lbis_pkg::INDEX_W-1:0]  e_idx;
    logic                          e_last;

    logic [lbis_pkg::PCT_W-1:0]    cap;
    logic [lbis_pkg::PCT_W-1:0]    base;
    logic                          at_end;
    logic                          to_fall;
    logic [lbis_pkg::REM_W:0]      tr_sum;
    logic                          carry;
    logic [lbis_pkg::REM_W-1:0]    tr_new;
    logic [lbis_pkg::TQ_W-1:0]     tq_sum;
    logic [lbis_pkg::PCT_W-1:0]    tq_new;

    lbis_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_MUL_C),
        .i_dividend (r_on_c),
        .i_divisor  (r_step),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign o_pop     = (r_state == ST_IDLE) && i_qvalid;
    assign on_clamp  = (i_job.on_ms < lbis_pkg::TIME_W'(lbis_pkg::RAMP_MS))
                       ? lbis_pkg::TIME_W'(lbis_pkg::RAMP_MS) : i_job.on_ms;
    assign off_clamp = (i_job.off_ms < lbis_pkg::TIME_W'(lbis_pkg::RAMP_MS))
                       ? lbis_pkg::TIME_W'(lbis_pkg::RAMP_MS) : i_job.off_ms;
    assign step_raw  = lbis_pkg::STEP_W'(r_prod_s >> lbis_pkg::STEP_SH);

    assign cap  = r_job.dim ? lbis_pkg::PCT_W'(lbis_pkg::DIM_CAP)
                            : lbis_pkg::PCT_W'(lbis_pkg::FULL_PCT);
    assign base = r_job.dim ? lbis_pkg::PCT_W'(lbis_pkg::DIM_BASE) : '0;

    // Table walk: t(n) = floor(n * c / RAMP_MS) is kept as a clamped
    // quotient and a remainder, advanced by c / RAMP_MS and c % RAMP_MS.
    assign at_end  = r_idx == lbis_pkg::IDX_W'(lbis_pkg::DUTY_STEPS - 1);
    assign to_fall = !r_fall &&
                     ((lbis_pkg::TIME_W'(r_idx) + lbis_pkg::TIME_W'(1)) == r_qp);
    assign tr_sum  = (lbis_pkg::REM_W+1)'(r_tr) + (lbis_pkg::REM_W+1)'(r_rem);
    assign carry   = tr_sum >= (lbis_pkg::REM_W+1)'(lbis_pkg::RAMP_MS);
    assign tr_new  = carry ? lbis_pkg::REM_W'(tr_sum - (lbis_pkg::REM_W+1)'(lbis_pkg::RAMP_MS))
                           : lbis_pkg::REM_W'(tr_sum);
    assign tq_sum  = lbis_pkg::TQ_W'(r_tq) + lbis_pkg::TQ_W'(r_inc) + lbis_pkg::TQ_W'(carry);
    assign tq_new  = (tq_sum > lbis_pkg::TQ_W'(cap)) ? cap : lbis_pkg::PCT_W'(tq_sum);

    assign can_load = !r_ov || o_out.ready;
    assign fire     = e_emit && can_load;

    always_comb begin
        e_emit  = 1'b0;
        e_kind  = lbis_pkg::KIND_STEADY;
        e_red   = r_job.to_red;
        e_green = r_job.to_green;
        e_value = '0;
        e_idx   = '0;
        e_last  = 1'b0;
        case (r_state)
            ST_RSTEP: begin
                e_emit  = 1'b1;
                e_kind  = lbis_pkg::KIND_STEP;
                e_value = lbis_pkg::VALUE_W'(r_step);
            end
            ST_TABLE: begin
                e_emit  = 1'b1;
                e_kind  = lbis_pkg::KIND_DUTY;
                e_idx   = lbis_pkg::INDEX_W'(r_idx);
                if (r_fall) begin
                    e_value = lbis_pkg::VALUE_W'(lbis_pkg::PCT_W'(lbis_pkg::FULL_PCT) - r_tq);
                end else begin
                    e_value = lbis_pkg::VALUE_W'(base + r_tq);
                end
            end
            ST_BLINK: begin
                e_emit  = 1'b1;
                e_kind  = lbis_pkg::KIND_BLINK;
                e_value = lbis_pkg::VALUE_W'(1);
                e_last  = r_job.n_steady == 2'd0;
            end
            ST_STDY0: begin
                e_emit  = 1'b1;
                e_red   = r_job.s0.to_red;
                e_green = r_job.s0.to_green;
                e_value = lbis_pkg::VALUE_W'(r_job.s0.level);
                e_last  = r_job.n_steady == 2'd1;
            end
            ST_STDY1: begin
                e_emit  = 1'b1;
                e_red   = r_job.s1.to_red;
                e_green = r_job.s1.to_green;
                e_value = lbis_pkg::VALUE_W'(r_job.s1.level);
                e_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_qvalid) begin
                    if (i_job.ramp) begin
                        n_state = ST_MUL_S;
                    end else if (i_job.blink) begin
                        n_state = ST_BLINK;
                    end else begin
                        n_state = ST_STDY0;
                    end
                end
            end
            ST_MUL_S: n_state = ST_FIX_S;
            ST_FIX_S: n_state = ST_MUL_C;
            ST_MUL_C: n_state = ST_REC_C;
            ST_REC_C: n_state = ST_QUO_C;
            ST_QUO_C: n_state = ST_REM_C;
            ST_REM_C: n_state = ST_WAIT;
            ST_WAIT: begin
                if (!div_busy) begin
                    n_state = ST_RSTEP;
                end
            end
            ST_RSTEP: begin
                if (fire) begin
                    n_state = ST_TABLE;
                end
            end
            ST_TABLE: begin
                if (fire && at_end) begin
                    n_state = ST_BLINK;
                end
            end
            ST_BLINK: begin
                if (fire) begin
                    n_state = (r_job.n_steady == 2'd0) ? ST_IDLE : ST_STDY0;
                end
            end
            ST_STDY0: begin
                if (fire) begin
                    n_state = (r_job.n_steady == 2'd2) ? ST_STDY1 : ST_IDLE;
                end
            end
            ST_STDY1: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (fire) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_on_c <= on_clamp;
            r_sum  <= lbis_pkg::SUM_W'(on_clamp) + lbis_pkg::SUM_W'(off_clamp);
        end
        if (r_state == ST_MUL_S) begin
            r_prod_s <= r_sum * lbis_pkg::STEP_MUL_W'(lbis_pkg::STEP_MUL);
        end
        if (r_state == ST_FIX_S) begin
            r_step <= (step_raw == '0) ? lbis_pkg::STEP_W'(1) : step_raw;
        end
        if (r_state == ST_MUL_C) begin
            r_c <= lbis_pkg::C_W'(r_step) * (r_job.dim ? lbis_pkg::C_W'(lbis_pkg::DIM_SCALE)
                                                       : lbis_pkg::C_W'(lbis_pkg::FULL_PCT));
        end
        if (r_state == ST_REC_C) begin
            r_prod_c <= r_c * lbis_pkg::C_MUL_W'(lbis_pkg::C_MUL);
        end
        if (r_state == ST_QUO_C) begin
            r_inc <= lbis_pkg::INC_W'(r_prod_c >> lbis_pkg::C_SH);
        end
        if (r_state == ST_REM_C) begin
            r_rem <= lbis_pkg::REM_W'(r_c - lbis_pkg::C_W'(r_inc)
                                          * lbis_pkg::C_W'(lbis_pkg::RAMP_MS));
        end
        if ((r_state == ST_WAIT) && !div_busy) begin
            // A zero quotient still leaves the first entry on the rising side.
            r_qp   <= (div_q == '0) ? lbis_pkg::TIME_W'(1) : div_q;
            r_idx  <= '0;
            r_fall <= 1'b0;
            r_tq   <= '0;
            r_tr   <= '0;
        end
        if ((r_state == ST_TABLE) && fire) begin
            r_idx <= r_idx + lbis_pkg::IDX_W'(1);
            if (to_fall) begin
                r_fall <= 1'b1;
                r_tq   <= '0;
                r_tr   <= '0;
            end else begin
                r_tq <= tq_new;
                r_tr <= tr_new;
            end
        end
        if (fire) begin
            r_okind  <= e_kind;
            r_ored   <= e_red;
            r_ogreen <= e_green;
            r_ovalue <= e_value;
            r_oidx   <= e_idx;
            r_olast  <= e_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_okind;
    assign o_out.to_red      = r_ored;
    assign o_out.to_green    = r_ogreen;
    assign o_out.value       = r_ovalue;
    assign o_out.entry_index = r_oidx;
    assign o_out.last        = r_olast;

endmodule

// ===== rtl/led_breathing_indicator_sequencer_top.sv =====
// With the engine idle, an update passes the job queue, the engine state and the output
// register before its first command; a ramped blink first runs the step and table-split
// states and waits for the on-time/step divider. Commands leave one per cycle unless the
// output stalls; a ramped blink also holds the engine for the 50-entry duty table walk.
// Reset (synchronous, active low) turns both lights off, disables ramping and
// empties the job queue; there is no clearing pass.
// ---------------------------------------------------------------------------
// led_breathing_indicator_sequencer_top: red/green LED indicator sequencer
// Takes notification and battery light updates and emits steady, blink,
// ramp step and duty table commands for the red and green LEDs.
// ---------------------------------------------------------------------------
module led_breathing_indicator_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbis_in_if.sink     i_in,
    lbis_cfg_if.sink    i_cfg,
    lbis_out_if.source  o_out
);

    logic            push;
    logic            full;
    logic            qvalid;
    logic            pop;
    lbis_pkg::t_job  front_job;
    lbis_pkg::t_job  queue_job;

    lbis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    lbis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (qvalid),
        .i_pop   (pop),
        .o_job   (queue_job)
    );

    lbis_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (qvalid),
        .i_job    (queue_job),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
